// File: rtl/core/ssrb_pkg.sv
// ----------------------------------------------------------------------------
// ssrb_pkg: shared types and constants of the sorted result buffer
// Entry layout, action and status codes, sequencer states, result beat.
// ----------------------------------------------------------------------------
package ssrb_pkg;

	localparam int DEPTH_DEF = 64;   // default number of entry slots
	localparam int CNT_W     = 7;    // held, capacity and read counts
	localparam int POS_W     = 6;    // insert position port
	localparam int IDX_W     = 16;
	localparam int SCORE_W   = 20;
	localparam int TOTAL_W   = 9;
	localparam int MATCH_W   = 8;
	localparam int ACT_W     = 2;
	localparam int STAT_W    = 3;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_CLEAR  = 2'd1,
		ACT_READ   = 2'd2
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_INSERTED = 3'd0,
		ST_DROPPED  = 3'd1,
		ST_CLEARED  = 3'd2,
		ST_ENTRY    = 3'd3,
		ST_NONE     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_CMP,
		S_INS_PUT,
		S_RD_ISSUE,
		S_RD_EMIT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [IDX_W-1:0]   idx;
		logic [SCORE_W-1:0] score;
		logic [TOTAL_W-1:0] total;
		logic [MATCH_W-1:0] disp;
		logic [MATCH_W-1:0] file;
	} entry_t;

	// one result beat handed from the sequencer to the output register
	typedef struct packed {
		logic             load;
		status_t          status;
		logic [POS_W-1:0] pos;
		entry_t           entry;
		logic [CNT_W-1:0] held;
		logic [CNT_W-1:0] ret;
		logic             last;
	} result_t;

endpackage

// File: rtl/core/score_sorted_result_buffer_unit.sv
// ----------------------------------------------------------------------------
// score_sorted_result_buffer_unit: score-ordered result buffer
// Holds scored entries in descending score order; insert, clear and read.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one action beat: insert an entry
//   (item_index, score, match counts), clear the buffer, or read the top
//   read_limit entries. in_stall is high whenever the sequencer is busy, so
//   only one action is in flight at a time.
//   Output channel out_valid/out_stall returns one beat per insert or clear,
//   and one beat per returned entry (or a single "none" beat) for a read;
//   last marks the final beat of an action.
//   cfg_wr_en/cfg_wr_data set capacity_in_use; write it only while idle.
// Operation:
//   An insert scan starts at the lowest held slot and moves toward slot 0
//   one entry per cycle through the single memory read port and score
//   comparator, moving lower scores down as it goes. Clear, a dropped insert
//   and an insert into an empty buffer go straight to the response beat. A
//   read does a memory read, then a load into the output register, for each
//   returned entry, and gives a single "none" beat when it finds none.
// Reset empties the buffer and sets capacity to 64. A stalled receiver holds
// the output register and the sequencer waits; no beat is lost.
// ----------------------------------------------------------------------------
module score_sorted_result_buffer_unit
	import ssrb_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [CNT_W-1:0]   cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [ACT_W-1:0]   action,
	input  logic [IDX_W-1:0]   item_index,
	input  logic [SCORE_W-1:0] score,
	input  logic [MATCH_W-1:0] display_hits,
	input  logic [MATCH_W-1:0] filename_hits,
	input  logic [CNT_W-1:0]   read_limit,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [STAT_W-1:0]  status,
	output logic [POS_W-1:0]   insert_position,
	output logic [IDX_W-1:0]   entry_index,
	output logic [SCORE_W-1:0] entry_score,
	output logic [TOTAL_W-1:0] entry_match_total,
	output logic [MATCH_W-1:0] entry_display_hits,
	output logic [MATCH_W-1:0] entry_filename_hits,
	output logic [CNT_W-1:0]   held_count,
	output logic [CNT_W-1:0]   returned_count,
	output logic               last
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CNT_W-1:0] cap_q;
	logic             out_valid_q;
	result_t          out_q;
	result_t          emit;
	entry_t           in_entry;
	entry_t           wr_data;
	entry_t           rd_data;
	logic             idle;
	logic             in_fire;
	logic             out_free;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [AW-1:0]    rd_addr;

	// take a beat only with the sequencer idle
	assign in_stall = !idle;
	assign in_fire  = in_valid && idle;
	// output register is free when empty or being drained this cycle
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		in_entry.idx   = item_index;
		in_entry.score = score;
		in_entry.total = TOTAL_W'(display_hits) + TOTAL_W'(filename_hits);
		in_entry.disp  = display_hits;
		in_entry.file  = filename_hits;
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// output register: hold while stalled, load a new beat when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			out_q <= emit;
		end
	end

	assign out_valid           = out_valid_q;
	assign status              = out_q.status;
	assign insert_position     = out_q.pos;
	assign entry_index         = out_q.entry.idx;
	assign entry_score         = out_q.entry.score;
	assign entry_match_total   = out_q.entry.total;
	assign entry_display_hits  = out_q.entry.disp;
	assign entry_filename_hits = out_q.entry.file;
	assign held_count          = out_q.held;
	assign returned_count      = out_q.ret;
	assign last                = out_q.last;

	ssrb_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.action    (action),
		.in_entry  (in_entry),
		.read_limit(read_limit),
		.cap       (cap_q),
		.out_free  (out_free),
		.idle      (idle),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.emit      (emit)
	);

	ssrb_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

endmodule

// File: rtl/core/ssrb_store.sv
// ----------------------------------------------------------------------------
// ssrb_store: entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssrb_store
	import ssrb_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// File: rtl/core/ssrb_ctrl.sv
// ----------------------------------------------------------------------------
// ssrb_ctrl: sequencer of the sorted result buffer
// Walks the store one slot a cycle through a single score comparator for
// inserts, and one slot per result beat for reads.
// ----------------------------------------------------------------------------
module ssrb_ctrl
	import ssrb_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic [ACT_W-1:0] action,
	input  entry_t           in_entry,
	input  logic [CNT_W-1:0] read_limit,
	input  logic [CNT_W-1:0] cap,
	input  logic             out_free,
	output logic             idle,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output entry_t           wr_data,
	output logic [AW-1:0]    rd_addr,
	input  entry_t           rd_data,
	output result_t          emit
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [AW-1:0]    j_q, j_d;
	logic [AW-1:0]    k_q, k_d;
	logic [CNT_W-1:0] n_q, n_d;
	logic [AW-1:0]    pos_q, pos_d;
	status_t          status_q, status_d;
	entry_t           new_q, new_d;
	logic [CNT_W-1:0] limit;
	logic [CNT_W-1:0] n_req;
	logic             shift_down;
	logic             rd_last;

	assign limit      = (cap > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap;
	assign n_req      = (count_q < read_limit) ? count_q : read_limit;
	assign shift_down = rd_data.score < new_q.score;
	assign rd_last    = (CNT_W'(k_q) + CNT_W'(1)) == n_q;
	assign idle       = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		j_q      <= j_d;
		k_q      <= k_d;
		n_q      <= n_d;
		pos_q    <= pos_d;
		status_q <= status_d;
		new_q    <= new_d;
	end

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		j_d      = j_q;
		k_d      = k_q;
		n_d      = n_q;
		pos_d    = pos_q;
		status_d = status_q;
		new_d    = new_q;
		rd_addr  = j_q - AW'(1);
		wr_en    = 1'b0;
		wr_addr  = j_q + AW'(1);
		wr_data  = rd_data;
		emit     = '0;
		case (state_q)
			S_IDLE: begin
				// prefetch the lowest held slot for an insert scan
				rd_addr = AW'(count_q - CNT_W'(1));
				if (in_fire) begin
					case (action)
						ACT_INSERT: begin
							new_d = in_entry;
							pos_d = '0;
							if (count_q >= limit) begin
								status_d = ST_DROPPED;
								state_d  = S_RESP;
							end else if (count_q == '0) begin
								wr_en    = 1'b1;
								wr_addr  = '0;
								wr_data  = in_entry;
								count_d  = count_q + CNT_W'(1);
								status_d = ST_INSERTED;
								state_d  = S_RESP;
							end else begin
								j_d     = AW'(count_q - CNT_W'(1));
								state_d = S_INS_CMP;
							end
						end
						ACT_CLEAR: begin
							count_d  = '0;
							pos_d    = '0;
							status_d = ST_CLEARED;
							state_d  = S_RESP;
						end
						ACT_READ: begin
							pos_d = '0;
							if (n_req == '0) begin
								status_d = ST_NONE;
								state_d  = S_RESP;
							end else begin
								n_d     = n_req;
								k_d     = '0;
								state_d = S_RD_ISSUE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_INS_CMP: begin
				// move lower scores down one slot; stop at the first score not below
				wr_en = 1'b1;
				if (shift_down) begin
					wr_data = rd_data;
					if (j_q == '0) begin
						state_d = S_INS_PUT;
					end else begin
						j_d = j_q - AW'(1);
					end
				end else begin
					wr_data  = new_q;
					pos_d    = j_q + AW'(1);
					count_d  = count_q + CNT_W'(1);
					status_d = ST_INSERTED;
					state_d  = S_RESP;
				end
			end
			S_INS_PUT: begin
				wr_en    = 1'b1;
				wr_addr  = '0;
				wr_data  = new_q;
				pos_d    = '0;
				count_d  = count_q + CNT_W'(1);
				status_d = ST_INSERTED;
				state_d  = S_RESP;
			end
			S_RD_ISSUE: begin
				rd_addr = k_q;
				state_d = S_RD_EMIT;
			end
			S_RD_EMIT: begin
				rd_addr = k_q;
				if (out_free) begin
					emit.load   = 1'b1;
					emit.status = ST_ENTRY;
					emit.entry  = rd_data;
					emit.held   = count_q;
					emit.ret    = n_q;
					emit.last   = rd_last;
					if (rd_last) begin
						state_d = S_IDLE;
					end else begin
						k_d     = k_q + AW'(1);
						state_d = S_RD_ISSUE;
					end
				end
			end
			S_RESP: begin
				if (out_free) begin
					emit.load   = 1'b1;
					emit.status = status_q;
					emit.pos    = POS_W'(pos_q);
					emit.held   = count_q;
					emit.last   = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit.load |-> out_free)
		else $error("result beat loaded into a busy output register");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> CNT_W'(wr_addr) <= count_q)
		else $error("store write beyond the held region");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_CMP || state_q == S_INS_PUT) |-> count_q != '0
		&& count_q < CNT_W'(DEPTH))
		else $error("insert scan with empty or full buffer");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && $past(state_q) != S_RESP && status_q == ST_INSERTED)
		|-> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not advance the held count");
`endif

endmodule

// File: tb/sv/ssrb_check_pkg.sv
// ----------------------------------------------------------------------------
// ssrb_check_pkg: ranked list tracking for the sorted result buffer bench
// Mirrors the buffer contents, lists the beats each action must produce and
// compares every returned beat, field by field, against the oldest one.
// ----------------------------------------------------------------------------
package ssrb_check_pkg;
	import ssrb_pkg::*;

	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam int               SLOTS      = DEPTH_DEF;
	localparam int               PRINT_CAP  = 50;

	typedef struct {
		status_t          status;
		logic [POS_W-1:0] pos;
		entry_t           entry;
		logic [CNT_W-1:0] held;
		logic [CNT_W-1:0] ret;
		logic             last;
	} beat_t;

	class ranked_list_checker;
		entry_t      ranked_entries[SLOTS];
		int unsigned held_entries;
		int unsigned capacity;
		beat_t       awaited_beats[$];
		int unsigned beats_seen;
		int unsigned mismatches;
		int unsigned placed, dropped, clears, entries_read, empty_reads, peak_held;

		function new();
			held_entries = 0;
			capacity     = CAP_RESET;
			beats_seen   = 0;
			mismatches   = 0;
			placed       = 0;
			dropped      = 0;
			clears       = 0;
			entries_read = 0;
			empty_reads  = 0;
			peak_held    = 0;
		endfunction

		function void set_capacity(logic [CNT_W-1:0] value);
			capacity = value;
		endfunction

		function int unsigned pending();
			return awaited_beats.size();
		endfunction

		function void await_beat(status_t st, logic [POS_W-1:0] pos, entry_t e,
				logic [CNT_W-1:0] ret, logic fin);
			beat_t b;
			b.status = st;
			b.pos    = pos;
			b.entry  = e;
			b.held   = CNT_W'(held_entries);
			b.ret    = ret;
			b.last   = fin;
			awaited_beats.push_back(b);
		endfunction

		// work out the beats one accepted action must produce
		function void note_action(logic [ACT_W-1:0] act, logic [IDX_W-1:0] new_idx,
				logic [SCORE_W-1:0] new_score, logic [MATCH_W-1:0] new_disp,
				logic [MATCH_W-1:0] new_file, logic [CNT_W-1:0] want_count);
			entry_t      fresh;
			int unsigned room;
			int unsigned slot;
			int unsigned n;
			room = (capacity > SLOTS) ? SLOTS : capacity;
			case (act)
				ACT_INSERT: begin
					if (held_entries >= room) begin
						await_beat(ST_DROPPED, '0, '0, '0, 1'b1);
						dropped++;
					end else begin
						fresh.idx   = new_idx;
						fresh.score = new_score;
						fresh.disp  = new_disp;
						fresh.file  = new_file;
						fresh.total = TOTAL_W'(new_disp) + TOTAL_W'(new_file);
						// place ahead of the first strictly lower score
						slot = held_entries;
						for (int i = 0; i < int'(held_entries); i++) begin
							if (ranked_entries[i].score < new_score) begin
								slot = i;
								break;
							end
						end
						for (int i = int'(held_entries); i > int'(slot); i--)
							ranked_entries[i] = ranked_entries[i-1];
						ranked_entries[slot] = fresh;
						held_entries++;
						if (held_entries > peak_held)
							peak_held = held_entries;
						await_beat(ST_INSERTED, POS_W'(slot), '0, '0, 1'b1);
						placed++;
					end
				end
				ACT_CLEAR: begin
					held_entries = 0;
					await_beat(ST_CLEARED, '0, '0, '0, 1'b1);
					clears++;
				end
				ACT_READ: begin
					n = (held_entries < want_count) ? held_entries : want_count;
					if (n == 0) begin
						await_beat(ST_NONE, '0, '0, '0, 1'b1);
						empty_reads++;
					end else begin
						for (int k = 0; k < int'(n); k++)
							await_beat(ST_ENTRY, '0, ranked_entries[k], CNT_W'(n),
								(k + 1 == int'(n)));
						entries_read += n;
					end
				end
				default: ;
			endcase
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			if (mismatches <= PRINT_CAP)
				$display("ERROR %0t ns: %s", $time, msg);
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report_mismatch($sformatf("beat %0d %s: got 0x%0h, want 0x%0h",
					beats_seen, name, got, want));
		endtask

		task check_beat(beat_t got);
			beat_t want;
			beats_seen++;
			if (awaited_beats.size() == 0) begin
				report_mismatch($sformatf(
					"beat %0d arrived with nothing awaited (status %0d)",
					beats_seen, got.status));
				return;
			end
			want = awaited_beats.pop_front();
			compare_field("status", got.status, want.status);
			compare_field("insert_position", got.pos, want.pos);
			compare_field("entry_index", got.entry.idx, want.entry.idx);
			compare_field("entry_score", got.entry.score, want.entry.score);
			compare_field("entry_match_total", got.entry.total, want.entry.total);
			compare_field("entry_display_hits", got.entry.disp, want.entry.disp);
			compare_field("entry_filename_hits", got.entry.file, want.entry.file);
			compare_field("held_count", got.held, want.held);
			compare_field("returned_count", got.ret, want.ret);
			compare_field("last", got.last, want.last);
		endtask

		task close_out();
			if (awaited_beats.size() != 0)
				report_mismatch($sformatf("%0d beats never arrived", awaited_beats.size()));
		endtask
	endclass

endpackage

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the score-ordered result buffer
// Drives insert, clear and read actions with random pacing on both channels,
// tracks the expected ranked contents and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ssrb_pkg::*;
	import ssrb_check_pkg::*;

	// longest stretch with no beat on either channel: sender gap, a full-depth
	// insert scan and a long receiver stall together stay well below it
	localparam int IDLE_LIMIT    = 3000;
	// settling time after the last awaited beat before the next phase
	localparam int SETTLE_CYCLES = 8;

	logic               clk                 = 1'b0;
	logic               arst_n              = 1'b0;
	logic               cfg_wr_en           = 1'b0;
	logic [CNT_W-1:0]   cfg_wr_data         = '0;
	logic               in_valid            = 1'b0;
	logic               in_stall;
	logic [ACT_W-1:0]   action              = '0;
	logic [IDX_W-1:0]   item_index          = '0;
	logic [SCORE_W-1:0] score               = '0;
	logic [MATCH_W-1:0] display_hits        = '0;
	logic [MATCH_W-1:0] filename_hits       = '0;
	logic [CNT_W-1:0]   read_limit          = '0;
	logic               out_valid;
	logic               out_stall           = 1'b0;
	logic [STAT_W-1:0]  status;
	logic [POS_W-1:0]   insert_position;
	logic [IDX_W-1:0]   entry_index;
	logic [SCORE_W-1:0] entry_score;
	logic [TOTAL_W-1:0] entry_match_total;
	logic [MATCH_W-1:0] entry_display_hits;
	logic [MATCH_W-1:0] entry_filename_hits;
	logic [CNT_W-1:0]   held_count;
	logic [CNT_W-1:0]   returned_count;
	logic               last;

	ranked_list_checker tracker;
	int unsigned        small_cap;

	score_sorted_result_buffer_unit #(
		.DEPTH(DEPTH_DEF)
	) dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_wr_en           (cfg_wr_en),
		.cfg_wr_data         (cfg_wr_data),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.action              (action),
		.item_index          (item_index),
		.score               (score),
		.display_hits        (display_hits),
		.filename_hits       (filename_hits),
		.read_limit          (read_limit),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.status              (status),
		.insert_position     (insert_position),
		.entry_index         (entry_index),
		.entry_score         (entry_score),
		.entry_match_total   (entry_match_total),
		.entry_display_hits  (entry_display_hits),
		.entry_filename_hits (entry_filename_hits),
		.held_count          (held_count),
		.returned_count      (returned_count),
		.last                (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Offer one action beat after a random gap and hold it until the block
	// takes it. Valid stays high on return, so a zero gap on the next call
	// moves straight on to the next beat without a low pulse.
	task automatic send_action(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
			input logic [SCORE_W-1:0] sc, input logic [MATCH_W-1:0] disp_hits,
			input logic [MATCH_W-1:0] file_hits, input logic [CNT_W-1:0] req);
		int gap;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			gap = 0;
		else if (pick < 85)
			gap = $urandom_range(1, 3);
		else if (pick < 97)
			gap = $urandom_range(4, 10);
		else
			gap = $urandom_range(20, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		action        <= act;
		item_index    <= idx;
		score         <= sc;
		display_hits  <= disp_hits;
		filename_hits <= file_hits;
		read_limit    <= req;
		in_valid      <= 1'b1;
		// pre-edge stall decides acceptance at this edge
		do @(posedge clk); while (in_stall);
		tracker.note_action(act, idx, sc, disp_hits, file_hits, req);
	endtask

	// Drop valid, let every awaited beat come back, then wait out the settling
	// time before the next phase.
	task automatic drain_and_pause();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only call while idle; the register loads at the next edge.
	task automatic write_capacity(input logic [CNT_W-1:0] value);
		cfg_wr_data <= value;
		cfg_wr_en   <= 1'b1;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		tracker.set_capacity(value);
	endtask

	// Mostly inserts with random content, some reads, rare clears and a
	// sprinkle of unused actions; ties come from a small pool of scores.
	// Close with a full read so the held contents are dumped and checked.
	task automatic run_random_phase(input logic [CNT_W-1:0] cap, input int items,
			input int clear_pct);
		int               done;
		int               pick;
		logic [SCORE_W-1:0] sc;
		logic [CNT_W-1:0] req;
		drain_and_pause();
		write_capacity(cap);
		done = 0;
		while (done < items) begin
			pick = $urandom_range(0, 99);
			if (pick < clear_pct) begin
				send_action(ACT_CLEAR, IDX_W'($urandom), SCORE_W'($urandom),
					MATCH_W'($urandom), MATCH_W'($urandom), CNT_W'($urandom_range(0, 64)));
				done++;
			end else if (pick < clear_pct + 15) begin
				case ($urandom_range(0, 9))
					0, 1:    req = CNT_W'(64);
					2:       req = '0;
					3:       req = CNT_W'(1);
					default: req = CNT_W'($urandom_range(0, 64));
				endcase
				send_action(ACT_READ, IDX_W'($urandom), SCORE_W'($urandom),
					MATCH_W'($urandom), MATCH_W'($urandom), req);
				done++;
			end else if (pick < clear_pct + 17) begin
				// noise: the block ignores it, so it does not count
				send_action(ACT_UNUSED, IDX_W'($urandom), SCORE_W'($urandom),
					MATCH_W'($urandom), MATCH_W'($urandom), CNT_W'($urandom_range(0, 64)));
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2: sc = SCORE_W'($urandom_range(0, 3) * 1000);
					3:       sc = '0;
					4:       sc = '1;
					default: sc = SCORE_W'($urandom);
				endcase
				send_action(ACT_INSERT, IDX_W'($urandom), sc, MATCH_W'($urandom),
					MATCH_W'($urandom), CNT_W'($urandom_range(0, 64)));
				done++;
			end
		end
		send_action(ACT_READ, '0, '0, '0, '0, CNT_W'(64));
	endtask

	// Receiver pacing: runs with no stall, mostly short stalls, a few
	// long ones, so stalls can land on any beat of a multi-beat read.
	initial begin : sink_pacing
		int span;
		int pick;
		forever begin
			@(posedge clk);
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				out_stall <= 1'b0;
				span = $urandom_range(1, 20);
			end else if (pick < 85) begin
				out_stall <= 1'b1;
				span = $urandom_range(1, 3);
			end else if (pick < 95) begin
				out_stall <= 1'b1;
				span = $urandom_range(4, 12);
			end else begin
				out_stall <= 1'b1;
				span = $urandom_range(20, 40);
			end
			repeat (span - 1) @(posedge clk);
		end
	end

	// Sample result beats on the edge where they are taken.
	always @(posedge clk) begin : result_monitor
		beat_t seen;
		if (arst_n && out_valid && !out_stall) begin
			seen.status      = status_t'(status);
			seen.pos         = insert_position;
			seen.entry.idx   = entry_index;
			seen.entry.score = entry_score;
			seen.entry.total = entry_match_total;
			seen.entry.disp  = entry_display_hits;
			seen.entry.file  = entry_filename_hits;
			seen.held        = held_count;
			seen.ret         = returned_count;
			seen.last        = last;
			tracker.check_beat(seen);
		end
	end

	// End the run if no beat moves on either channel for too long.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		tracker = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset capacity: empty read, field extremes,
		// equal-score ordering, zero and partial reads, unused action, clear.
		send_action(ACT_READ, '0, '0, '0, '0, CNT_W'(64));
		send_action(ACT_INSERT, '0, '0, '0, '0, '0);
		send_action(ACT_INSERT, '1, '1, '1, '1, CNT_W'(64));
		send_action(ACT_INSERT, IDX_W'(16'h1234), SCORE_W'(500), MATCH_W'(3), MATCH_W'(4), '0);
		send_action(ACT_INSERT, IDX_W'(2), SCORE_W'(500), MATCH_W'(9), MATCH_W'(1), '0);
		send_action(ACT_INSERT, IDX_W'(3), '0, MATCH_W'(128), MATCH_W'(127), '0);
		send_action(ACT_READ, '0, '0, '0, '0, '0);
		send_action(ACT_READ, '0, '0, '0, '0, CNT_W'(1));
		send_action(ACT_READ, '0, '0, '0, '0, CNT_W'(64));
		send_action(ACT_UNUSED, '1, '1, '1, '1, CNT_W'(64));
		send_action(ACT_CLEAR, '0, '0, '0, '0, '0);
		send_action(ACT_READ, '0, '0, '0, '0, CNT_W'(64));

		// Small capacity: the third insert drops even with the top score.
		drain_and_pause();
		write_capacity(CNT_W'(2));
		send_action(ACT_INSERT, IDX_W'(10), SCORE_W'(20), MATCH_W'(1), MATCH_W'(2), '0);
		send_action(ACT_INSERT, IDX_W'(11), SCORE_W'(40), MATCH_W'(3), MATCH_W'(4), '0);
		send_action(ACT_INSERT, IDX_W'(12), '1, MATCH_W'(5), MATCH_W'(6), '0);
		send_action(ACT_READ, '0, '0, '0, '0, CNT_W'(3));

		// Capacity lowered below the held count: held entries stay, inserts
		// drop until a clear.
		drain_and_pause();
		write_capacity(CNT_W'(1));
		send_action(ACT_INSERT, IDX_W'(13), '1, '0, '0, '0);
		send_action(ACT_READ, '0, '0, '0, '0, CNT_W'(64));
		send_action(ACT_CLEAR, '0, '0, '0, '0, '0);
		send_action(ACT_INSERT, IDX_W'(14), SCORE_W'(7), MATCH_W'(8), MATCH_W'(9), '0);
		send_action(ACT_INSERT, IDX_W'(15), SCORE_W'(9), MATCH_W'(1), MATCH_W'(1), '0);

		// Zero capacity: every insert drops.
		drain_and_pause();
		write_capacity('0);
		send_action(ACT_CLEAR, '0, '0, '0, '0, '0);
		send_action(ACT_INSERT, IDX_W'(16), '1, '1, '1, '0);
		send_action(ACT_READ, '0, '0, '0, '0, CNT_W'(64));

		// Random part: capacity above depth fills all slots and drops the
		// overflow, then a small capacity while full, then the reset value.
		small_cap = $urandom_range(1, 8);
		run_random_phase('1, 90, 0);
		run_random_phase(CNT_W'(small_cap), 20, 10);
		run_random_phase(CNT_W'(64), 20, 5);

		drain_and_pause();
		tracker.close_out();
		$display("covered %0d inserts placed, %0d dropped, %0d clears,",
			tracker.placed, tracker.dropped, tracker.clears);
		$display("  %0d entries read, %0d empty reads",
			tracker.entries_read, tracker.empty_reads);
		$display("capacities 64, 2, 1, 0, 127, %0d, 64; deepest fill %0d; %0d mismatches",
			small_cap, tracker.peak_held, tracker.mismatches);
		if (tracker.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
